// File: hdl/daf_pkg.sv
`default_nettype none

package daf_pkg;

    // Field widths fixed by the item format.
    localparam int VALUE_W     = 16;
    localparam int COUNT_W     = 3;
    localparam int POINT_W     = 3;
    localparam int IN_DATA_W   = 24;
    localparam int CHAR_W      = 8;
    localparam int DIGITS      = 5;
    localparam int BCD_W       = 4 * DIGITS;
    localparam int CONV_STEPS  = 8;
    localparam int STEP_W      = 3;

    // Most significant figures that one item can ask for.
    localparam logic [COUNT_W-1:0] MAX_FIGURES = 3'd5;

    // Characters.
    localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_ALIGN,
        S_EMIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic step;
        logic align;
        logic emit_point;
        logic emit_digit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic count_zero;
        logic conv_last;
        logic out_free;
        logic point_pending;
        logic is_final;
    } t_status;

endpackage

`default_nettype wire

// File: hdl/daf_ctrl.sv
`default_nettype none

module daf_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire daf_pkg::t_status i_status,
    output daf_pkg::t_cmd         o_cmd,
    output logic                  o_in_ready
);
    import daf_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && !i_status.count_zero) begin
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                if (i_status.conv_last) begin
                    n_state = S_ALIGN;
                end
            end
            S_ALIGN: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_status.out_free && !i_status.point_pending && i_status.is_final) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_CONV: begin
                o_cmd.step = 1'b1;
            end
            S_ALIGN: begin
                o_cmd.align = 1'b1;
            end
            S_EMIT: begin
                o_cmd.emit_point = i_status.out_free && i_status.point_pending;
                o_cmd.emit_digit = i_status.out_free && !i_status.point_pending;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hdl/daf_datapath.sv
`default_nettype none

module daf_datapath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [daf_pkg::IN_DATA_W-1:0] i_in_data,
    input  wire daf_pkg::t_cmd                 i_cmd,
    output daf_pkg::t_status                   o_status,
    input  wire logic                          i_out_ready,
    output logic                               o_out_valid,
    output logic [daf_pkg::CHAR_W-1:0]         o_out_char,
    output logic                               o_out_last
);
    import daf_pkg::*;

    // One double-dabble step: correct each decimal digit, then shift in one bit.
    function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] b, input logic bin_bit);
        logic [BCD_W-1:0] c;
        c = b;
        for (int k = 0; k < DIGITS; k++) begin
            if (c[4*k +: 4] >= 4'd5) begin
                c[4*k +: 4] = c[4*k +: 4] + 4'd3;
            end
        end
        return {c[BCD_W-2:0], bin_bit};
    endfunction

    // Move the most significant nonzero digit to the top; zero stays as it is.
    function automatic logic [BCD_W-1:0] align_top(input logic [BCD_W-1:0] b);
        logic [BCD_W-1:0] a;
        if (b[19:16] != 4'd0) begin
            a = b;
        end else if (b[15:12] != 4'd0) begin
            a = {b[15:0], 4'd0};
        end else if (b[11:8] != 4'd0) begin
            a = {b[11:0], 8'd0};
        end else if (b[7:4] != 4'd0) begin
            a = {b[7:0], 12'd0};
        end else begin
            a = {b[3:0], 16'd0};
        end
        return a;
    endfunction

    logic [VALUE_W-1:0] in_value;
    logic [COUNT_W-1:0] in_count;
    logic [POINT_W-1:0] in_point;
    logic [COUNT_W-1:0] sat_count;
    logic [BCD_W-1:0]   bcd_half;

    logic [BCD_W-1:0]   r_bcd;
    logic [VALUE_W-1:0] r_bin;
    logic [STEP_W-1:0]  r_step;
    logic [COUNT_W-1:0] r_count;
    logic [POINT_W-1:0] r_point;
    logic [COUNT_W-1:0] r_fig;
    logic               r_point_done;
    logic               r_out_valid;
    logic [CHAR_W-1:0]  r_out_char;
    logic               r_out_last;

    // Unpack the input item.
    assign in_value  = i_in_data[15:0];
    assign in_count  = i_in_data[18:16];
    assign in_point  = i_in_data[21:19];
    assign sat_count = (in_count > MAX_FIGURES) ? MAX_FIGURES : in_count;

    // First of the two conversion bits handled per cycle.
    assign bcd_half = dabble(r_bcd, r_bin[VALUE_W-1]);

    // Conversion, alignment and figure bookkeeping.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_bcd        <= '0;
            r_bin        <= in_value;
            r_step       <= '0;
            r_count      <= sat_count;
            r_point      <= in_point;
            r_fig        <= '0;
            r_point_done <= 1'b0;
        end else if (i_cmd.step) begin
            r_bcd  <= dabble(bcd_half, r_bin[VALUE_W-2]);
            r_bin  <= {r_bin[VALUE_W-3:0], 2'b00};
            r_step <= r_step + STEP_W'(1);
        end else if (i_cmd.align) begin
            r_bcd <= align_top(r_bcd);
        end else if (i_cmd.emit_point) begin
            r_point_done <= 1'b1;
        end else if (i_cmd.emit_digit) begin
            r_bcd        <= {r_bcd[BCD_W-5:0], 4'd0};
            r_fig        <= r_fig + COUNT_W'(1);
            r_point_done <= 1'b0;
        end
    end

    // Output register towards the receiver.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_point || i_cmd.emit_digit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_point) begin
            r_out_char <= CHAR_POINT;
            r_out_last <= 1'b0;
        end else if (i_cmd.emit_digit) begin
            r_out_char <= CHAR_ZERO + {4'd0, r_bcd[BCD_W-1 -: 4]};
            r_out_last <= o_status.is_final;
        end
    end

    // Status for the controller.
    assign o_status.count_zero    = (in_count == '0);
    assign o_status.conv_last     = (r_step == STEP_W'(CONV_STEPS - 1));
    assign o_status.out_free      = !r_out_valid || i_out_ready;
    assign o_status.point_pending = (r_fig == r_point) && !r_point_done;
    assign o_status.is_final      = (COUNT_W'(r_fig + COUNT_W'(1)) == r_count);

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_out_last  = r_out_last;

endmodule

`default_nettype wire

// File: hdl/decimal_ascii_formatter.sv
// Decimal ASCII formatter.
// The slave channel takes one number per item: a 16-bit unsigned value, a
// count of significant figures (1 to 5, larger counts act as 5) and a point
// position. The master channel returns the number as ASCII characters, one
// per item, starting at the most significant nonzero digit; a '.' goes before
// the figure whose index equals the point position, figures past the units
// digit come out as '0', and tlast marks the final character.
// An accepted number first runs through the binary-to-decimal converter,
// which handles two bits per cycle, then the align step brings the leading
// digit to the top. The characters follow one per cycle while the receiver
// takes them. A number gives up to 6 characters; s_axis_tready is high only
// between numbers. A count of zero is accepted and gives no characters.
// When the receiver stalls, the output register holds its character and
// emission pauses. Reset (synchronous, active low) returns the controller to
// idle and empties the output register.
`default_nettype none

module decimal_ascii_formatter (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // value [15:0], digit_count [18:16], point_position [21:19], unused [23:22]
    input  wire logic [daf_pkg::IN_DATA_W-1:0] s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // char_byte [7:0]
    output logic [daf_pkg::CHAR_W-1:0]         m_axis_tdata,
    output logic                               m_axis_tlast
);
    import daf_pkg::*;

    t_cmd    cmd;
    t_status status;

    // Sequencing of conversion and emission.
    daf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_ready (s_axis_tready)
    );

    // Conversion registers and output register.
    daf_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (s_axis_tdata),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_char  (m_axis_tdata),
        .o_out_last  (m_axis_tlast)
    );

endmodule

`default_nettype wire

// File: hdl/daf_checker.sv
`default_nettype none

module daf_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [23:0] s_axis_tdata,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [7:0]  m_axis_tdata,
    input wire logic        m_axis_tlast
);
    import daf_pkg::*;

    // A stalled character holds its value and its last flag.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled output item changed");

    // A point is always followed by a digit, so it never closes a number.
    a_point_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata == CHAR_POINT) |-> !m_axis_tlast)
        else $error("point item carries tlast");

    // Only decimal digits and the point are ever sent.
    a_char_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata == CHAR_POINT) ||
            ((m_axis_tdata >= CHAR_ZERO) && (m_axis_tdata <= CHAR_ZERO + 8'd9)))
        else $error("output item is not a digit or a point");

    // Once a number with figures is taken, no further number is taken at once.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tdata[18:16] != 3'd0) |=>
            !s_axis_tready)
        else $error("input taken while a number is in progress");

endmodule

bind decimal_ascii_formatter daf_checker u_daf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// File: verif/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import daf_pkg::*;

    // Cycles without any accepted item before the run is abandoned.
    localparam int unsigned HANG_LIMIT = 3000;
    // Cycles allowed after the last expected character, covering one whole number.
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned RANDOM_PER_PHASE = 63;

    // Expected characters of the formatted numbers, oldest first.
    class char_scoreboard;
        localparam int unsigned DEC_BASE = 10;

        typedef struct packed {
            logic [CHAR_W-1:0] ch;
            logic              last;
        } t_char;

        t_char       pending_chars[$];
        int unsigned errors;
        int unsigned chars_checked;

        function new();
            errors = 0;
            chars_checked = 0;
        endfunction

        // Work out the characters for one accepted number.
        function void note_number(logic [VALUE_W-1:0] value, logic [COUNT_W-1:0] count,
                                  logic [POINT_W-1:0] point);
            int unsigned weight;
            int unsigned figures;
            int unsigned digit;
            t_char       c;
            weight = 1;
            while (weight * DEC_BASE <= value) begin
                weight = weight * DEC_BASE;
            end
            figures = 32'((count > MAX_FIGURES) ? MAX_FIGURES : count);
            for (int unsigned i = 0; i < figures; i++) begin
                if (i == point) begin
                    c.ch = CHAR_POINT;
                    c.last = 1'b0;
                    pending_chars.push_back(c);
                end
                // Once the weight runs out the figures are past the units digit.
                digit = (weight != 0) ? (value / weight) % DEC_BASE : 0;
                c.ch = CHAR_ZERO + digit[CHAR_W-1:0];
                c.last = (i + 1 == figures);
                pending_chars.push_back(c);
                weight = weight / DEC_BASE;
            end
        endfunction

        // Compare one received character with the oldest expectation.
        function void check_char(logic [CHAR_W-1:0] ch, logic last);
            t_char want;
            if (pending_chars.size() == 0) begin
                errors++;
                $display("%0t: unexpected character 0x%02h last %0b", $time, ch, last);
                return;
            end
            want = pending_chars.pop_front();
            chars_checked++;
            if (want.ch !== ch) begin
                errors++;
                $display("%0t: char mismatch, expected 0x%02h, actual 0x%02h",
                         $time, want.ch, ch);
            end
            if (want.last !== last) begin
                errors++;
                $display("%0t: tlast mismatch, expected %0b, actual %0b",
                         $time, want.last, last);
            end
        endfunction

        function int unsigned outstanding();
            return pending_chars.size();
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [CHAR_W-1:0]    m_axis_tdata;
    logic                 m_axis_tlast;

    char_scoreboard sb = new();

    int unsigned sender_idle_pct;
    int unsigned receiver_stall_pct;
    int unsigned numbers_sent;
    int unsigned directed_count;
    int unsigned quiet_cycles;

    decimal_ascii_formatter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Clock with a 2 ns period.
    initial begin
        i_clk = 1'b0;
    end

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Receiver stalls at random according to the current phase.
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Every character accepted by the receiver is checked.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_char(m_axis_tdata, m_axis_tlast);
        end
    end

    // Watchdog: gives up when neither side has moved an item for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= HANG_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, HANG_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Offer one number, with a random idle gap first, and wait for it to be taken.
    // Called and left at a falling edge.
    task automatic send_number(logic [VALUE_W-1:0] value, logic [COUNT_W-1:0] count,
                               logic [POINT_W-1:0] point);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'b00, point, count, value};
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        sb.note_number(value, count, point);
        numbers_sent++;
        @(negedge i_clk);
    endtask

    // Random number with a spread of magnitudes, so short values often run past
    // their units digit; counts and points cover their whole fields.
    task automatic send_random_number();
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] count;
        logic [POINT_W-1:0] point;
        case ($urandom_range(5))
            0: value = VALUE_W'($urandom_range(9));
            1: value = VALUE_W'($urandom_range(99));
            2: value = VALUE_W'($urandom_range(999));
            3: value = VALUE_W'($urandom_range(9999));
            default: value = VALUE_W'($urandom_range(65535));
        endcase
        if ($urandom_range(9) == 0) begin
            count = COUNT_W'($urandom_range(7));
        end else begin
            count = COUNT_W'($urandom_range(MAX_FIGURES, 1));
        end
        point = POINT_W'($urandom_range(7));
        send_number(value, count, point);
    endtask

    task automatic run_random_phase(int unsigned idle_pct, int unsigned stall_pct);
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        repeat (RANDOM_PER_PHASE) begin
            send_random_number();
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        numbers_sent = 0;
        quiet_cycles = 0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed numbers: field extremes, zero, short values and the point cases.
        send_number(16'd0, 3'd1, 3'd7);
        send_number(16'd0, 3'd5, 3'd0);
        send_number(16'd65535, 3'd5, 3'd7);
        send_number(16'd65535, 3'd5, 3'd0);
        send_number(16'd65535, 3'd7, 3'd4);
        send_number(16'd12345, 3'd6, 3'd2);
        send_number(16'd12345, 3'd0, 3'd0);
        send_number(16'd0, 3'd0, 3'd7);
        send_number(16'd1, 3'd1, 3'd0);
        send_number(16'd9, 3'd5, 3'd1);
        send_number(16'd10, 3'd5, 3'd2);
        send_number(16'd99, 3'd3, 3'd3);
        send_number(16'd100, 3'd5, 3'd3);
        send_number(16'd10000, 3'd5, 3'd4);
        send_number(16'd9999, 3'd4, 3'd5);
        send_number(16'd7, 3'd2, 3'd1);
        send_number(16'd43690, 3'd3, 3'd6);
        send_number(16'd21845, 3'd5, 3'd5);
        send_number(16'd1000, 3'd2, 3'd1);
        send_number(16'd32768, 3'd1, 3'd1);
        directed_count = numbers_sent;

        // Random numbers under the four handshake pressure phases.
        run_random_phase(0, 0);
        run_random_phase(72, 0);
        run_random_phase(0, 72);
        run_random_phase(17, 17);
        s_axis_tvalid <= 1'b0;

        while (sb.outstanding() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.outstanding() != 0) begin
            sb.errors += sb.outstanding();
            $display("%0t: %0d characters never arrived", $time, sb.outstanding());
        end
        $display("Formatted %0d numbers (%0d directed) into %0d checked characters,",
                 numbers_sent, directed_count, sb.chars_checked);
        $display("under free flow, sender gaps, receiver stalls and both together.");
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
